// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold on every clock outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/psm_pkg.sv =====
`timescale 1ns / 1ps

package psm_pkg;

  // store depth, derived index width and payload widths
  localparam int DEPTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W = 6;
  localparam int VAL_W = 32;

  // input beat payload
  typedef struct packed {
    logic signed [VAL_W-1:0] sample_value;
    logic                    final_sample;
  } psm_in_t;

  // result beat payload
  typedef struct packed {
    logic        [POS_W-1:0] position;
    logic signed [VAL_W-1:0] prefix_min;
    logic signed [VAL_W-1:0] suffix_min;
    logic                    last_result;
  } psm_out_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_BACK,
    ST_EMIT
  } psm_state_t;

  // signed minimum
  function automatic logic signed [VAL_W-1:0] smin(
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] b
  );
    smin = (b < a) ? b : a;
  endfunction

endpackage

// ===== hdl/prefix_suffix_minima_top.sv =====
// sequence: a run of beats is loaded, the backward pass walks it from the last entry down,
// then the forward pass emits the results from entry zero up
// throughput: loading takes one beat per cycle; results leave at one per cycle while out_ready
// is high, set by the single read port of each store
// reset: rst_n (synchronous, active low) clears the sequencer and counters; stores are not cleared
`timescale 1ns / 1ps
`include "assert_macros.svh"

module prefix_suffix_minima_top
  import psm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  psm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output psm_out_t out_data
);

  // value and suffix stores
  logic [VAL_W-1:0] value_mem  [DEPTH];
  logic [VAL_W-1:0] suffix_mem [DEPTH];

  psm_state_t state_r, state_nxt;

  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] last_idx_r, last_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             rd_done_r, rd_done_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic signed [VAL_W-1:0] run_r, run_nxt;
  logic signed [VAL_W-1:0] val_rd_r;
  logic signed [VAL_W-1:0] suf_rd_r;
  logic             out_valid_r, out_valid_nxt;
  psm_out_t         out_data_r;

  logic in_fire;
  logic run_end;
  logic issue;
  logic load_out;
  logic back_wr;
  logic signed [VAL_W-1:0] back_min;
  logic signed [VAL_W-1:0] fwd_min;

  // beat and pass events
  assign in_fire  = in_valid && in_ready;
  assign run_end  = in_data.final_sample || (cnt_r == IDX_W'(DEPTH - 1));
  assign back_min = (pend_idx_r == last_idx_r) ? val_rd_r : smin(val_rd_r, run_r);
  assign fwd_min  = (pend_idx_r == '0) ? val_rd_r : smin(val_rd_r, run_r);

  // control outputs per state
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    back_wr  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
      end
      ST_BACK: begin
        issue   = !rd_done_r;
        back_wr = pend_r;
      end
      ST_EMIT: begin
        load_out = pend_r && (!out_valid_r || out_ready);
        issue    = !rd_done_r && (!pend_r || load_out);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire && run_end) begin
          state_nxt = ST_BACK;
        end
      end
      ST_BACK: begin
        if (pend_r && (pend_idx_r == '0)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out && (pend_idx_r == last_idx_r)) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // counters, read sequencing and running minimum
  always_comb begin
    cnt_nxt      = cnt_r;
    last_idx_nxt = last_idx_r;
    rd_idx_nxt   = rd_idx_r;
    rd_done_nxt  = rd_done_r;
    pend_idx_nxt = pend_idx_r;
    run_nxt      = run_r;
    pend_nxt     = pend_r;
    case (state_r)
      ST_LOAD: begin
        pend_nxt = 1'b0;
        if (in_fire) begin
          if (run_end) begin
            cnt_nxt      = '0;
            last_idx_nxt = cnt_r;
            rd_idx_nxt   = cnt_r;
            rd_done_nxt  = 1'b0;
          end else begin
            cnt_nxt = cnt_r + IDX_W'(1);
          end
        end
      end
      ST_BACK: begin
        // walk down from the last entry, one read per cycle
        pend_nxt = issue;
        if (issue) begin
          pend_idx_nxt = rd_idx_r;
          if (rd_idx_r == '0) begin
            rd_done_nxt = 1'b1;
          end else begin
            rd_idx_nxt = rd_idx_r - IDX_W'(1);
          end
        end
        if (pend_r) begin
          run_nxt = back_min;
          if (pend_idx_r == '0) begin
            rd_idx_nxt  = '0;
            rd_done_nxt = 1'b0;
          end
        end
      end
      ST_EMIT: begin
        // walk up from entry zero, held reads wait for the output register
        if (load_out) begin
          run_nxt = fwd_min;
        end
        if (issue) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_idx_r;
          if (rd_idx_r == last_idx_r) begin
            rd_done_nxt = 1'b1;
          end else begin
            rd_idx_nxt = rd_idx_r + IDX_W'(1);
          end
        end else if (load_out) begin
          pend_nxt = 1'b0;
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      last_idx_r  <= '0;
      rd_idx_r    <= '0;
      rd_done_r   <= 1'b0;
      pend_r      <= 1'b0;
      pend_idx_r  <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_idx_r  <= last_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_done_r   <= rd_done_nxt;
      pend_r      <= pend_nxt;
      pend_idx_r  <= pend_idx_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // value store: written during load, read in both passes; passes never overlap a write
  always_ff @(posedge clk) begin
    if (in_fire) begin
      value_mem[cnt_r] <= in_data.sample_value;
    end
    if (issue) begin
      val_rd_r <= value_mem[rd_idx_r];
    end
  end

  // suffix store: written by the backward pass, read while emitting
  always_ff @(posedge clk) begin
    if (back_wr) begin
      suffix_mem[pend_idx_r] <= back_min;
    end
    if (issue) begin
      suf_rd_r <= suffix_mem[rd_idx_r];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.position    <= POS_W'(pend_idx_r);
      out_data_r.prefix_min  <= fwd_min;
      out_data_r.suffix_min  <= suf_rd_r;
      out_data_r.last_result <= (pend_idx_r == last_idx_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `ASSERT_IMPL(a_no_pend_in_load, clk, rst_n, state_r == ST_LOAD, !pend_r,
               "read in flight while loading")
  `ASSERT_IMPL(a_back_idx_range, clk, rst_n, pend_r && (state_r == ST_BACK),
               pend_idx_r <= last_idx_r, "backward pass index past run end")
  `ASSERT_NEXT(a_run_end_starts_pass, clk, rst_n, in_fire && run_end,
               (state_r == ST_BACK) && (cnt_r == '0), "run end did not start backward pass")

endmodule
